// ----- src/bfpc_pkg.sv -----
// Package for the body-frame position command block: types, codes, constants and the
// CORDIC arctangent table. Used by the controller, the datapath and the top.

package bfpc_pkg;

    // Default values for the top-level parameters.
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 18;

    // Inverse CORDIC gain in Q30 and guard bits for the rotation.
    localparam logic [32:0] INV_GAIN_Q30 = 33'd652032874;
    localparam int          GUARD        = 8;
    localparam int          INV_SHIFT    = 30 - GUARD;

    // Divide-by-ten unit: floor(n/10) = floor(n * ceil(2^38/10) / 2^38), exact for
    // every numerator below 2^34. The numerator is multiplied in two halves.
    localparam int                 DIV_W       = 34;
    localparam int                 DIV_HALF    = DIV_W / 2;
    localparam int                 RECIP_W     = 35;
    localparam logic [RECIP_W-1:0] RECIP_TEN   = 35'd27487790695;
    localparam int                 RECIP_SHIFT = 38;
    localparam int                 DIV_STEPS   = 3;

    // Reset values of the configuration registers.
    localparam logic signed [31:0] TARGET_RST  = 32'sd0;
    localparam logic [30:0]        MAXCOR_RST  = 31'd65536;
    localparam logic signed [31:0] BASEALT_RST = 32'sd65536;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_TARGET_X  = 3'd0,
        CFG_TARGET_Y  = 3'd1,
        CFG_MAX_CORR  = 3'd2,
        CFG_ROBOT_MOD = 3'd3,
        CFG_BASE_ALT  = 3'd4
    } t_cfg_idx;

    // Operand pairs for the shared multiplier.
    typedef enum logic [2:0] {
        MUL_WZ = 3'd0,
        MUL_XY = 3'd1,
        MUL_YY = 3'd2,
        MUL_ZZ = 3'd3,
        MUL_EX = 3'd4,
        MUL_EY = 3'd5
    } t_mul_sel;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_VEC,
        ST_RINIT,
        ST_ROT,
        ST_POST,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     vec_init;
        logic     rot_init;
        logic     cordic_step;
        logic     vec_mode;
        logic [4:0] step_idx;
        logic     post;
        logic     sum;
        logic     div_step;
        logic     out_load;
    } t_dp_cmd;

    // Arctangent of 2^-i as a 32-bit binary angle.
    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ----- src/bfpc_pose_if.sv -----
// Input channel interface carrying one pose transaction.
// Depends on nothing but the standard logic types.

interface bfpc_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [17:0] quat_x;
    logic signed [17:0] quat_y;
    logic signed [17:0] quat_z;
    logic signed [17:0] quat_w;
    logic signed [31:0] height_adjust;

    modport source (output valid, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                    height_adjust, input ready);
    modport sink   (input valid, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                    height_adjust, output ready);
endinterface

// ----- src/bfpc_cmd_if.sv -----
// Output channel interface carrying one command transaction.
// Depends on nothing but the standard logic types.

interface bfpc_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] cmd_x;
    logic signed [31:0] cmd_y;
    logic signed [31:0] cmd_z;
    logic [30:0]        speed_estimate;

    modport source (output valid, cmd_x, cmd_y, cmd_z, speed_estimate, input ready);
    modport sink   (input valid, cmd_x, cmd_y, cmd_z, speed_estimate, output ready);
endinterface

// ----- src/bfpc_ctrl.sv -----
// Controller state machine: sequences multiplies, CORDIC steps and the divider.
// Depends on bfpc_pkg for the state type and the datapath command struct.

module bfpc_ctrl #(
    parameter int CORDIC_STEPS = bfpc_pkg::CORDIC_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output bfpc_pkg::t_dp_cmd o_cmd
);

    localparam int MUL_LAST = 6;
    localparam int LIM_A    = (CORDIC_STEPS > bfpc_pkg::DIV_STEPS) ?
                              CORDIC_STEPS : bfpc_pkg::DIV_STEPS;
    localparam int LIM      = (LIM_A > MUL_LAST) ? LIM_A : MUL_LAST;
    localparam int CNT_W    = $clog2(LIM + 1);

    bfpc_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bfpc_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and counter.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            bfpc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = bfpc_pkg::ST_MUL;
                    n_cnt   = '0;
                end
            end
            bfpc_pkg::ST_MUL: begin
                if (r_cnt == CNT_W'(MUL_LAST)) begin
                    n_state = bfpc_pkg::ST_VEC;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            bfpc_pkg::ST_VEC: begin
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    n_state = bfpc_pkg::ST_RINIT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            bfpc_pkg::ST_RINIT: begin
                n_state = bfpc_pkg::ST_ROT;
                n_cnt   = '0;
            end
            bfpc_pkg::ST_ROT: begin
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    n_state = bfpc_pkg::ST_POST;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            bfpc_pkg::ST_POST: begin
                n_state = bfpc_pkg::ST_SUM;
            end
            bfpc_pkg::ST_SUM: begin
                n_state = bfpc_pkg::ST_DIV;
                n_cnt   = '0;
            end
            bfpc_pkg::ST_DIV: begin
                if (r_cnt == CNT_W'(bfpc_pkg::DIV_STEPS - 1)) begin
                    n_state = bfpc_pkg::ST_DONE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            bfpc_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = bfpc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bfpc_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands, handshake outputs and the output valid flag.
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.step_idx = 5'(r_cnt);
        unique case (r_state)
            bfpc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            bfpc_pkg::ST_MUL: begin
                o_cmd.mul_en   = (r_cnt != CNT_W'(MUL_LAST));
                o_cmd.mul_sel  = bfpc_pkg::t_mul_sel'(r_cnt[2:0]);
                o_cmd.vec_init = (r_cnt == CNT_W'(MUL_LAST));
            end
            bfpc_pkg::ST_VEC: begin
                o_cmd.cordic_step = 1'b1;
                o_cmd.vec_mode    = 1'b1;
            end
            bfpc_pkg::ST_RINIT: begin
                o_cmd.rot_init = 1'b1;
            end
            bfpc_pkg::ST_ROT: begin
                o_cmd.cordic_step = 1'b1;
            end
            bfpc_pkg::ST_POST: begin
                o_cmd.post = 1'b1;
            end
            bfpc_pkg::ST_SUM: begin
                o_cmd.sum = 1'b1;
            end
            bfpc_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            bfpc_pkg::ST_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- src/bfpc_dp.sv -----
// Datapath: configuration registers, shared multiplier, shared CORDIC iteration,
// clamp and axis mapping, divide-by-ten unit and output registers. Depends on bfpc_pkg.

module bfpc_dp #(
    parameter int FRAC_BITS = bfpc_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bfpc_pkg::t_dp_cmd  i_cmd,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [17:0] i_quat_x,
    input  logic signed [17:0] i_quat_y,
    input  logic signed [17:0] i_quat_z,
    input  logic signed [17:0] i_quat_w,
    input  logic signed [31:0] i_height_adjust,
    output logic signed [31:0] o_cmd_x,
    output logic signed [31:0] o_cmd_y,
    output logic signed [31:0] o_cmd_z,
    output logic [30:0]        o_speed_estimate
);

    // Yaw term width and CORDIC register width.
    localparam int TW   = (2 * FRAC_BITS + 2 > 39) ? 2 * FRAC_BITS + 2 : 39;
    localparam int CW   = (TW + 3 > 44) ? TW + 3 : 44;
    localparam int DW   = bfpc_pkg::DIV_W;
    localparam int PW   = 66;
    localparam int MW   = bfpc_pkg::DIV_HALF + bfpc_pkg::RECIP_W;
    localparam int SW   = DW + bfpc_pkg::RECIP_W;

    // Configuration registers.
    logic signed [31:0] r_target_x, r_target_y, r_base_alt;
    logic [30:0]        r_max_corr;
    logic               r_mode;

    // Captured item.
    logic signed [17:0] r_qx, r_qy, r_qz, r_qw;
    logic signed [32:0] r_ex, r_ey;

    // Multiplier and accumulators.
    logic signed [PW-1:0] r_prod;
    logic                 r_prod_vld;
    bfpc_pkg::t_mul_sel   r_prod_sel;
    logic signed [TW-1:0] r_acc33, r_acc44;
    logic signed [CW-1:0] r_a, r_b;

    // CORDIC state.
    logic signed [CW-1:0] r_x, r_y;
    logic [31:0]          r_z;
    logic                 r_t33_zero;

    // Results.
    logic signed [31:0] r_cx, r_cy, r_cz, r_prev_x, r_prev_y;
    logic [DW-1:0]      r_num;
    logic [MW-1:0]      r_plo, r_phi;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x <= bfpc_pkg::TARGET_RST;
            r_target_y <= bfpc_pkg::TARGET_RST;
            r_max_corr <= bfpc_pkg::MAXCOR_RST;
            r_mode     <= 1'b0;
            r_base_alt <= bfpc_pkg::BASEALT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bfpc_pkg::CFG_TARGET_X:  r_target_x <= $signed(i_cfg_data);
                bfpc_pkg::CFG_TARGET_Y:  r_target_y <= $signed(i_cfg_data);
                bfpc_pkg::CFG_MAX_CORR:  r_max_corr <= i_cfg_data[30:0];
                bfpc_pkg::CFG_ROBOT_MOD: r_mode     <= i_cfg_data[0];
                bfpc_pkg::CFG_BASE_ALT:  r_base_alt <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Shared multiplier operand selection.
    logic signed [32:0]   mul_a, mul_b;
    logic signed [PW-1:0] mul_p;

    always_comb begin
        unique case (i_cmd.mul_sel)
            bfpc_pkg::MUL_WZ: begin mul_a = 33'(r_qw); mul_b = 33'(r_qz); end
            bfpc_pkg::MUL_XY: begin mul_a = 33'(r_qx); mul_b = 33'(r_qy); end
            bfpc_pkg::MUL_YY: begin mul_a = 33'(r_qy); mul_b = 33'(r_qy); end
            bfpc_pkg::MUL_ZZ: begin mul_a = 33'(r_qz); mul_b = 33'(r_qz); end
            bfpc_pkg::MUL_EX: begin
                mul_a = r_ex;
                mul_b = $signed(bfpc_pkg::INV_GAIN_Q30);
            end
            bfpc_pkg::MUL_EY: begin
                mul_a = r_ey;
                mul_b = $signed(bfpc_pkg::INV_GAIN_Q30);
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Yaw terms and the start of the vectoring pass.
    logic signed [TW-1:0] t33, t44;
    assign t33 = r_acc33 <<< 1;
    assign t44 = (TW'(1) << (2 * FRAC_BITS)) - (r_acc44 <<< 1);

    // Rotation start angle, folded into the right half plane.
    logic [31:0] th;
    logic        fold;
    assign th   = r_t33_zero ? 32'd0 : 32'd0 - r_z;
    assign fold = ($signed(th) > 32'sh40000000) || ($signed(th) < -32'sh40000000);

    // One CORDIC iteration, shared by vectoring and rotation.
    logic signed [CW-1:0] sh_x, sh_y;
    logic [31:0]          atn;
    logic                 plus;
    assign sh_x = r_x >>> i_cmd.step_idx;
    assign sh_y = r_y >>> i_cmd.step_idx;
    assign atn  = bfpc_pkg::atan_lut(i_cmd.step_idx);
    assign plus = i_cmd.vec_mode ? !(r_y > 0) : !r_z[31];

    // Drop guard bits, clamp and map the axes.
    logic signed [CW-1:0] gx, gy, lim, cl_x, cl_y;
    logic signed [31:0]   xu, yu;
    assign gx   = r_x >>> bfpc_pkg::GUARD;
    assign gy   = r_y >>> bfpc_pkg::GUARD;
    assign lim  = CW'($signed({1'b0, r_max_corr}));
    assign cl_y = (gy > lim) ? lim : ((gy < -lim) ? -lim : gy);
    assign cl_x = (gx > lim) ? lim : ((gx < -lim) ? -lim : gx);
    assign xu   = 32'(cl_y);
    assign yu   = 32'(cl_x);

    // Summed absolute command change.
    logic signed [32:0] dx, dy;
    logic [32:0]        adx, ady;
    assign dx  = 33'(r_cx) - 33'(r_prev_x);
    assign dy  = 33'(r_cy) - 33'(r_prev_y);
    assign adx = dx[32] ? 33'(-dx) : 33'(dx);
    assign ady = dy[32] ? 33'(-dy) : 33'(dy);

    // Divide by ten by reciprocal multiplication: the low half of the numerator is
    // multiplied in the first step, the high half in the second, and the third step
    // adds the two partial products and keeps the quotient bits.
    logic [bfpc_pkg::DIV_HALF-1:0] div_half;
    logic [MW-1:0]                 div_prod;
    logic [SW-1:0]                 div_sum;
    assign div_half = (i_cmd.step_idx == 5'd0) ? r_num[bfpc_pkg::DIV_HALF-1:0]
                                               : r_num[DW-1:bfpc_pkg::DIV_HALF];
    assign div_prod = MW'(div_half) * MW'(bfpc_pkg::RECIP_TEN);
    assign div_sum  = {r_phi, {bfpc_pkg::DIV_HALF{1'b0}}} + SW'(r_plo);

    // Altitude command, saturated.
    logic signed [32:0] alt_sum;
    assign alt_sum = 33'(r_base_alt) + 33'(i_height_adjust);

    // Product tag is control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mul_en;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_qx <= i_quat_x;
            r_qy <= i_quat_y;
            r_qz <= i_quat_z;
            r_qw <= i_quat_w;
            r_ex <= 33'(i_pos_x) - 33'(r_target_x);
            r_ey <= 33'(i_pos_y) - 33'(r_target_y);
            if (alt_sum > 33'sh07FFFFFFF) begin
                r_cz <= 32'sh7FFFFFFF;
            end else if (alt_sum < -33'sh080000000) begin
                r_cz <= 32'sh80000000;
            end else begin
                r_cz <= 32'(alt_sum);
            end
        end

        if (i_cmd.mul_en) begin
            r_prod     <= mul_p;
            r_prod_sel <= i_cmd.mul_sel;
        end

        // Accumulate the product of the previous cycle.
        if (r_prod_vld) begin
            unique case (r_prod_sel)
                bfpc_pkg::MUL_WZ: r_acc33 <= TW'(r_prod);
                bfpc_pkg::MUL_XY: r_acc33 <= r_acc33 + TW'(r_prod);
                bfpc_pkg::MUL_YY: r_acc44 <= TW'(r_prod);
                bfpc_pkg::MUL_ZZ: r_acc44 <= r_acc44 + TW'(r_prod);
                bfpc_pkg::MUL_EX: r_a <= CW'(r_prod >>> bfpc_pkg::INV_SHIFT);
                bfpc_pkg::MUL_EY: r_b <= CW'(r_prod >>> bfpc_pkg::INV_SHIFT);
                default: ;
            endcase
        end

        // CORDIC register set: vectoring start, rotation start or one iteration.
        if (i_cmd.vec_init) begin
            r_t33_zero <= (r_acc33 == '0);
            if (t44 < 0) begin
                r_x <= -CW'(t44);
                r_y <= -CW'(t33);
                r_z <= 32'h80000000;
            end else begin
                r_x <= CW'(t44);
                r_y <= CW'(t33);
                r_z <= 32'd0;
            end
        end else if (i_cmd.rot_init) begin
            if (fold) begin
                r_x <= -r_a;
                r_y <= -r_b;
                r_z <= th + 32'h80000000;
            end else begin
                r_x <= r_a;
                r_y <= r_b;
                r_z <= th;
            end
        end else if (i_cmd.cordic_step) begin
            if (plus) begin
                r_x <= r_x - sh_y;
                r_y <= r_y + sh_x;
                r_z <= r_z - atn;
            end else begin
                r_x <= r_x + sh_y;
                r_y <= r_y - sh_x;
                r_z <= r_z + atn;
            end
        end

        if (i_cmd.post) begin
            r_cx <= r_mode ? yu : -xu;
            r_cy <= r_mode ? xu : yu;
        end

        if (i_cmd.div_step) begin
            if (i_cmd.step_idx == 5'd0) begin
                r_plo <= div_prod;
            end else if (i_cmd.step_idx == 5'd1) begin
                r_phi <= div_prod;
            end else begin
                r_num <= DW'(div_sum[SW-1:bfpc_pkg::RECIP_SHIFT]);
            end
        end else if (i_cmd.sum) begin
            r_num <= DW'(adx) + DW'(ady);
        end

        if (i_cmd.out_load) begin
            o_cmd_x          <= r_cx;
            o_cmd_y          <= r_cy;
            o_cmd_z          <= r_cz;
            o_speed_estimate <= r_num[30:0];
        end
    end

    // Previous command, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x <= '0;
            r_prev_y <= '0;
        end else if (i_cmd.sum) begin
            r_prev_x <= r_cx;
            r_prev_y <= r_cy;
        end
    end

endmodule

// ----- src/body_frame_position_command_unit.sv -----
// Body-frame position command unit, top level.
// The shared CORDIC unit runs the vectoring and rotation passes one step a cycle.
// One item is worked on at a time; a new input is taken once the previous result is in
// the output register.
// Synchronous active-low reset restores the register defaults and clears the previous command.

module body_frame_position_command_unit #(
    parameter int FRAC_BITS    = bfpc_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = bfpc_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bfpc_pose_if.sink   i_pose,
    bfpc_cmd_if.source  o_cmd,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    bfpc_pkg::t_dp_cmd dp_cmd;
    logic              in_ready;
    logic              out_valid;

    // Sequencing.
    bfpc_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pose.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_cmd.ready),
        .o_cmd       (dp_cmd)
    );

    // Arithmetic.
    bfpc_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_pos_x          (i_pose.pos_x),
        .i_pos_y          (i_pose.pos_y),
        .i_quat_x         (i_pose.quat_x),
        .i_quat_y         (i_pose.quat_y),
        .i_quat_z         (i_pose.quat_z),
        .i_quat_w         (i_pose.quat_w),
        .i_height_adjust  (i_pose.height_adjust),
        .o_cmd_x          (o_cmd.cmd_x),
        .o_cmd_y          (o_cmd.cmd_y),
        .o_cmd_z          (o_cmd.cmd_z),
        .o_speed_estimate (o_cmd.speed_estimate)
    );

    assign i_pose.ready = in_ready;
    assign o_cmd.valid  = out_valid;

endmodule

// ----- tb/sv/bfpc_cmd_checker.sv -----
// Checker for the body-frame position command unit: watches the pose and command
// channels, predicts each command and compares it. Depends on bfpc_pkg and the interfaces.
`timescale 1ns / 100ps

module bfpc_cmd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bfpc_pose_if        pose,
    bfpc_cmd_if         cmd,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [30:0]        spd;
    } t_cmd_exp;

    localparam longint INV_GAIN = 64'sd652032874;

    // Shadow copy of the configuration and the previous planar command.
    longint tgt_x, tgt_y, max_corr, base_alt, last_cx, last_cy;
    bit     robot_mode;
    t_cmd_exp cmd_queue[$];

    // Arctangent steps as in the datapath, kept here as plain constants.
    longint atan_steps[32] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
        64'h00000001, 64'h00000000};

    function automatic longint clamp_corr(longint v);
        if (v > max_corr) return max_corr;
        if (v < -max_corr) return -max_corr;
        return v;
    endfunction

    // Heading of (x, y) as a 32-bit binary angle by vectoring.
    function automatic logic [31:0] heading_of(longint x, longint y);
        logic [31:0] z;
        longint sx, sy;
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < bfpc_pkg::CORDIC_STEPS_DEF; i++) begin
            sx = y >>> i;
            sy = x >>> i;
            if (y > 0) begin
                x += sx; y -= sy; z += atan_steps[i][31:0];
            end else begin
                x -= sx; y += sy; z -= atan_steps[i][31:0];
            end
        end
        return z;
    endfunction

    // Works out the command for one pose and advances the previous command.
    function automatic t_cmd_exp predict_command(longint px, longint py, longint qx,
                                                 longint qy, longint qz, longint qw,
                                                 longint hz);
        t_cmd_exp r;
        longint t33, t44, a, b, z, sx, sy, xu, yu, cx, cy, cz, dx, dy, sp;
        logic [31:0] th;
        t33 = 2 * (qw * qz + qx * qy);
        t44 = (64'sd1 <<< (2 * bfpc_pkg::FRAC_BITS_DEF)) - 2 * (qy * qy + qz * qz);
        th  = (t33 == 0) ? 32'd0 : 32'd0 - heading_of(t44, t33);
        a = ((px - tgt_x) * INV_GAIN) >>> bfpc_pkg::INV_SHIFT;
        b = ((py - tgt_y) * INV_GAIN) >>> bfpc_pkg::INV_SHIFT;
        z = longint'(signed'(th));
        if (z > 64'sh40000000 || z < -64'sh40000000) begin
            a = -a;
            b = -b;
            z = (z > 0) ? z - 64'sh80000000 : z + 64'sh80000000;
        end
        for (int i = 0; i < bfpc_pkg::CORDIC_STEPS_DEF; i++) begin
            sx = b >>> i;
            sy = a >>> i;
            if (z >= 0) begin
                a -= sx; b += sy; z -= atan_steps[i];
            end else begin
                a += sx; b -= sy; z += atan_steps[i];
            end
        end
        xu = clamp_corr(b >>> bfpc_pkg::GUARD);
        yu = clamp_corr(a >>> bfpc_pkg::GUARD);
        if (robot_mode) begin
            cx = yu; cy = xu;
        end else begin
            cx = -xu; cy = yu;
        end
        cz = base_alt + hz;
        if (cz > 64'sh7FFFFFFF) cz = 64'sh7FFFFFFF;
        if (cz < -64'sh80000000) cz = -64'sh80000000;
        dx = cx - last_cx; if (dx < 0) dx = -dx;
        dy = cy - last_cy; if (dy < 0) dy = -dy;
        sp = (dx + dy) / 10;
        if (sp > 64'sh7FFFFFFF) sp = 64'sh7FFFFFFF;
        last_cx = cx;
        last_cy = cy;
        r.cx = cx[31:0]; r.cy = cy[31:0]; r.cz = cz[31:0]; r.spd = sp[30:0];
        return r;
    endfunction

    assign o_pending = cmd_queue.size();

    // Track configuration, predict on each pose transaction, compare each command.
    always @(posedge i_clk) begin
        t_cmd_exp got, want;
        if (!i_rst_n) begin
            tgt_x = 0; tgt_y = 0; max_corr = bfpc_pkg::MAXCOR_RST; robot_mode = 0;
            base_alt = bfpc_pkg::BASEALT_RST; last_cx = 0; last_cy = 0;
            cmd_queue.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bfpc_pkg::CFG_TARGET_X:  tgt_x = longint'(signed'(i_cfg_data));
                    bfpc_pkg::CFG_TARGET_Y:  tgt_y = longint'(signed'(i_cfg_data));
                    bfpc_pkg::CFG_MAX_CORR:  max_corr = longint'(i_cfg_data[30:0]);
                    bfpc_pkg::CFG_ROBOT_MOD: robot_mode = i_cfg_data[0];
                    bfpc_pkg::CFG_BASE_ALT:  base_alt = longint'(signed'(i_cfg_data));
                    default: ;
                endcase
            end
            if (pose.valid && pose.ready)
                cmd_queue.push_back(predict_command(pose.pos_x, pose.pos_y, pose.quat_x,
                    pose.quat_y, pose.quat_z, pose.quat_w, pose.height_adjust));
            if (cmd.valid && cmd.ready) begin
                got = '{cmd.cmd_x, cmd.cmd_y, cmd.cmd_z, cmd.speed_estimate};
                if (cmd_queue.size() == 0) begin
                    $display("%0t: command with none expected: %p", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = cmd_queue.pop_front();
                    if (got !== want) begin
                        $display("%0t: command mismatch: expected %p, actual %p",
                                 $time, want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- tb/sv/body_frame_position_command_unit_tb.sv -----
// Testbench top for the body-frame position command unit: clock, reset, pose stimulus,
// configuration phases and verdict. Depends on bfpc_pkg, the interfaces and the checker.
`timescale 1ns / 100ps

module body_frame_position_command_unit_tb;

    localparam int WATCHDOG_LIMIT = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [31:0] cfg_data = '0;
    int          fail_count, pending, idle_cycles;
    bit          sink_ready_mode;

    bfpc_pose_if pose_ch ();
    bfpc_cmd_if  cmd_ch ();

    body_frame_position_command_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pose(pose_ch.sink), .o_cmd(cmd_ch.source),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data));

    bfpc_cmd_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .pose(pose_ch), .cmd(cmd_ch),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending));

    always #6 i_clk = ~i_clk;

    initial begin
        pose_ch.valid = 1'b0;
        {pose_ch.pos_x, pose_ch.pos_y, pose_ch.height_adjust} = '0;
        {pose_ch.quat_x, pose_ch.quat_y, pose_ch.quat_z, pose_ch.quat_w} = '0;
        cmd_ch.ready = 1'b0;
    end

    // Result side: a random stall before each transaction, unless sink_ready_mode is set.
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = sink_ready_mode ? 0 : $urandom_range(0, 13);
            if (stall != 0) begin
                cmd_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            cmd_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!cmd_ch.valid);
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((pose_ch.valid && pose_ch.ready) || (cmd_ch.valid && cmd_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(bfpc_pkg::t_cfg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Drops the input valid, waits for every expected command, then lets the block settle.
    task automatic drain_commands();
        pose_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    // Sends one pose transaction after a random gap, none when no_gap is set; returns at
    // the falling edge after the transaction, leaving the valid to the next call or to the drain.
    task automatic send_pose(logic [31:0] px, logic [31:0] py, logic [17:0] qx,
                             logic [17:0] qy, logic [17:0] qz, logic [17:0] qw,
                             logic [31:0] hz, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            pose_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pose_ch.valid <= 1'b1;
        pose_ch.pos_x <= px; pose_ch.pos_y <= py;
        pose_ch.quat_x <= qx; pose_ch.quat_y <= qy;
        pose_ch.quat_z <= qz; pose_ch.quat_w <= qw;
        pose_ch.height_adjust <= hz;
        do @(posedge i_clk); while (!pose_ch.ready);
        @(negedge i_clk);
    endtask

    function automatic logic [17:0] rand_quat();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 18'sd65536;
        if (sel == 1) return -18'sd65536;
        if (sel == 2) return 18'd0;
        return 18'($urandom_range(0, 131072) - 65536);
    endfunction

    // Mostly modest positions near zero, sometimes full-range values.
    function automatic logic [31:0] rand_pos();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endfunction

    initial begin
        logic [31:0] big_pos, neg_pos;
        bit burst;
        big_pos = 32'h7FFFFFFF;
        neg_pos = 32'h80000000;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed poses at reset settings: zero yaw, yaw of pi, zero quaternion,
        // quarter turns, unnormalised quaternion and extreme positions and heights.
        send_pose(32'h00010000, 32'h00020000, 0, 0, 0, 18'sd65536, 0, 0);
        send_pose(32'h00030000, 32'hFFFE0000, 0, 0, 18'sd65536, 0, 0, 0);
        send_pose(32'h00008000, 32'h00008000, 0, 0, 0, 0, 32'h7FFFFFFF, 0);
        send_pose(32'h00004000, 32'h00002000, 0, 0, 18'sd46341, 18'sd46341, 0, 0);
        send_pose(32'h00004000, 32'h00002000, 0, 0, -18'sd46341, 18'sd46341, 0, 0);
        send_pose(32'h00004000, 32'h00002000, 18'sd1000, 18'sd3000, 18'sd300, 18'sd20, 0, 0);
        send_pose(big_pos, neg_pos, 18'sd65536, 18'sd65536, -18'sd65536, -18'sd65536,
                  32'h80000000, 0);
        send_pose(neg_pos, big_pos, -18'sd65536, 0, 0, 0, 32'h7FFFFFFF, 0);
        send_pose(32'hFFFFFFFF, 32'h00000001, 18'sd12345, -18'sd23456, 18'sd3456, 18'sd61234,
                  32'h80000001, 0);
        drain_commands();

        // Extremes of the registers: zero clamp, widest clamp, robot axis mapping.
        write_reg(bfpc_pkg::CFG_TARGET_X, 32'h80000000);
        write_reg(bfpc_pkg::CFG_TARGET_Y, 32'h7FFFFFFF);
        write_reg(bfpc_pkg::CFG_MAX_CORR, 32'h00000000);
        write_reg(bfpc_pkg::CFG_ROBOT_MOD, 32'h1);
        write_reg(bfpc_pkg::CFG_BASE_ALT, 32'h7FFFFFFF);
        send_pose(32'h7FFFFFFF, neg_pos, 0, 0, 18'sd30000, 18'sd50000, 32'h7FFFFFFF, 0);
        send_pose(0, 0, 0, 0, 0, 18'sd65536, 32'h00000001, 0);
        drain_commands();
        write_reg(bfpc_pkg::CFG_MAX_CORR, 32'h7FFFFFFF);
        write_reg(bfpc_pkg::CFG_BASE_ALT, 32'h80000000);
        send_pose(32'h7FFFFFFF, neg_pos, 0, 0, 18'sd30000, 18'sd50000, 32'h80000000, 0);
        send_pose(neg_pos, 32'h7FFFFFFF, 18'sd5000, 0, 0, -18'sd65000, 32'hFFFFFFFF, 0);
        send_pose(0, 0, 0, 0, 0, 18'sd65536, 0, 0);
        drain_commands();

        // Random phases, each under a fresh register setting.
        for (int phase = 0; phase < 16; phase++) begin
            write_reg(bfpc_pkg::CFG_TARGET_X, rand_pos());
            write_reg(bfpc_pkg::CFG_TARGET_Y, rand_pos());
            write_reg(bfpc_pkg::CFG_MAX_CORR,
                      (phase % 4 == 0) ? $urandom : $urandom_range(0, 1 << 20));
            write_reg(bfpc_pkg::CFG_ROBOT_MOD, phase[0]);
            write_reg(bfpc_pkg::CFG_BASE_ALT, $urandom);
            sink_ready_mode = (phase % 5 == 4);
            burst = (phase % 5 == 3);
            for (int n = 0; n < 100; n++)
                send_pose(rand_pos(), rand_pos(), rand_quat(), rand_quat(), rand_quat(),
                          rand_quat(), $urandom, burst);
            drain_commands();
        end

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ----- sim.f -----
src/bfpc_pkg.sv
src/bfpc_pose_if.sv
src/bfpc_cmd_if.sv
src/bfpc_ctrl.sv
src/bfpc_dp.sv
src/body_frame_position_command_unit.sv
tb/sv/bfpc_cmd_checker.sv
tb/sv/body_frame_position_command_unit_tb.sv
